@@ src/ple_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types, request and status codes, and controller/datapath interface
// structs for the positional list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

	// store geometry
	localparam int LIST_CAPACITY = 64;
	localparam int ADDR_W        = $clog2(LIST_CAPACITY);
	localparam int CNT_W         = 7;

	// request codes
	localparam logic [1:0] REQ_GET    = 2'd0;
	localparam logic [1:0] REQ_SET    = 2'd1;
	localparam logic [1:0] REQ_INSERT = 2'd2;
	localparam logic [1:0] REQ_REMOVE = 2'd3;

	// result status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BAD_POS = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;

	// read address select
	localparam logic [2:0] RA_POS_M1 = 3'd0;
	localparam logic [2:0] RA_CNT_M1 = 3'd1;
	localparam logic [2:0] RA_IDX_M2 = 3'd2;
	localparam logic [2:0] RA_IDX_P1 = 3'd3;
	localparam logic [2:0] RA_IDX_P2 = 3'd4;

	// write select
	localparam logic WS_POS_VAL = 1'b0;
	localparam logic WS_IDX_RD  = 1'b1;

	// walk index operation
	localparam logic [2:0] IDX_HOLD     = 3'd0;
	localparam logic [2:0] IDX_SET_CNT  = 3'd1;
	localparam logic [2:0] IDX_SET_POS1 = 3'd2;
	localparam logic [2:0] IDX_DEC      = 3'd3;
	localparam logic [2:0] IDX_INC      = 3'd4;

	// request beat
	typedef struct packed {
		logic [1:0]        req_type;
		logic [CNT_W-1:0]  position;
		logic signed [31:0] value;
	} ple_req_t;

	// result beat
	typedef struct packed {
		logic [1:0]        status;
		logic signed [31:0] data;
		logic [CNT_W-1:0]  count;
		logic              is_empty;
		logic              is_full;
	} ple_rsp_t;

	// controller -> datapath
	typedef struct packed {
		logic       load;
		logic       store_status;
		logic       rd_en;
		logic [2:0] rd_sel;
		logic       wr_en;
		logic       wr_sel;
		logic [2:0] idx_op;
		logic       cnt_inc;
		logic       cnt_dec;
		logic       data_cap;
		logic       out_load;
	} ple_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [1:0] req_type;
		logic       err;
		logic       append;
		logic       ins_last;
		logic       rm_end;
		logic       rm_last;
		logic       out_busy;
	} ple_sts_t;

endpackage

@@ src/positional_list_engine_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_engine_core
// Ordered list of signed 32-bit values with get, set, insert and remove at a
// 1-based position; one result beat per request beat.
// ----------------------------------------------------------------------------
// One request is handled at a time. From acceptance, an error, a set or an
// append passes S_CHECK and S_DONE until the result register is loaded, a get
// adds S_RD_WAIT, a remove S_RM_DATA and S_RM unless it is at the end, and
// an insert that is not an append S_INS and S_INS_PUT: the shift moves one
// entry per cycle through the single write port of the element store. A new
// request is taken in the cycle after the previous result is loaded into the
// result register, even while that result still waits on rsp_ready. The store
// needs no clearing after reset; the count starts at zero.
module positional_list_engine_core import ple_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  ple_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output ple_rsp_t rsp
);

	ple_cmd_t cmd;
	ple_sts_t sts;

	ple_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ple_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	// one request in flight: no accept in the cycle after an accept
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while another is in flight");

	// count never passes capacity
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.count <= CNT_W'(LIST_CAPACITY))
		else $error("count above capacity");

	// flags agree with the count
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.is_empty == (rsp.count == '0)) &&
			(rsp.is_full == (rsp.count == CNT_W'(LIST_CAPACITY))))
		else $error("empty/full flags disagree with count");

	// errored requests return zero data
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_OK |-> rsp.data == '0)
		else $error("nonzero data on error status");

endmodule

@@ src/ple_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_datapath
// Element store, count, request registers, shift walk index and result
// register of the positional list engine.
// ----------------------------------------------------------------------------
module ple_datapath import ple_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  ple_req_t req,
	input  ple_cmd_t cmd,
	output ple_sts_t sts,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output ple_rsp_t rsp
);

	logic [31:0]       mem [LIST_CAPACITY];
	logic [31:0]       rd_s1;
	logic [1:0]        req_type_q;
	logic [CNT_W-1:0]  pos_q;
	logic [31:0]       val_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  idx_q;
	logic [1:0]        status_q;
	logic [31:0]       data_q;
	logic              out_valid_q;
	ple_rsp_t          rsp_q;

	logic [1:0]        status_c;
	logic [CNT_W:0]    cnt_p1;
	logic [CNT_W-1:0]  rd_idx;
	logic [CNT_W-1:0]  wr_idx;
	logic [31:0]       wr_data;
	logic [CNT_W-1:0]  cnt_next;

	// request registers, payload only
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_type_q <= req.req_type;
			pos_q      <= req.position;
			val_q      <= req.value;
		end
	end

	// position and capacity check
	assign cnt_p1 = {1'b0, cnt_q} + {{CNT_W{1'b0}}, 1'b1};
	always_comb begin
		status_c = ST_OK;
		if (req_type_q == REQ_INSERT) begin
			if (cnt_q >= CNT_W'(LIST_CAPACITY)) begin
				status_c = ST_FULL;
			end else if (pos_q == '0 || {1'b0, pos_q} > cnt_p1) begin
				status_c = ST_BAD_POS;
			end
		end else if (pos_q == '0 || pos_q > cnt_q) begin
			status_c = ST_BAD_POS;
		end
	end

	// read address select
	always_comb begin
		case (cmd.rd_sel)
			RA_POS_M1: rd_idx = pos_q - CNT_W'(1);
			RA_CNT_M1: rd_idx = cnt_q - CNT_W'(1);
			RA_IDX_M2: rd_idx = idx_q - CNT_W'(2);
			RA_IDX_P1: rd_idx = idx_q + CNT_W'(1);
			RA_IDX_P2: rd_idx = idx_q + CNT_W'(2);
			default:   rd_idx = pos_q - CNT_W'(1);
		endcase
	end

	// write address and data select
	assign wr_idx  = (cmd.wr_sel == WS_IDX_RD) ? idx_q : pos_q - CNT_W'(1);
	assign wr_data = (cmd.wr_sel == WS_IDX_RD) ? rd_s1 : val_q;

	// element store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[wr_idx[ADDR_W-1:0]] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_s1 <= mem[rd_idx[ADDR_W-1:0]];
		end
	end

	// shift walk index
	always_ff @(posedge clk) begin
		case (cmd.idx_op)
			IDX_HOLD:     idx_q <= idx_q;
			IDX_SET_CNT:  idx_q <= cnt_q;
			IDX_SET_POS1: idx_q <= pos_q - CNT_W'(1);
			IDX_DEC:      idx_q <= idx_q - CNT_W'(1);
			IDX_INC:      idx_q <= idx_q + CNT_W'(1);
			default:      idx_q <= idx_q;
		endcase
	end

	// status and data of the pending result
	always_ff @(posedge clk) begin
		if (cmd.store_status) begin
			status_q <= status_c;
		end
		if (cmd.load) begin
			data_q <= '0;
		end else if (cmd.data_cap) begin
			data_q <= rd_s1;
		end
	end

	// element count
	always_comb begin
		cnt_next = cnt_q;
		if (cmd.cnt_inc) begin
			cnt_next = cnt_q + CNT_W'(1);
		end else if (cmd.cnt_dec) begin
			cnt_next = cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			rsp_q.status   <= status_q;
			rsp_q.data     <= data_q;
			rsp_q.count    <= cnt_q;
			rsp_q.is_empty <= (cnt_q == '0);
			rsp_q.is_full  <= (cnt_q == CNT_W'(LIST_CAPACITY));
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = rsp_q;

	// status toward the controller
	assign sts.req_type = req_type_q;
	assign sts.err      = (status_c != ST_OK);
	assign sts.append   = ({1'b0, pos_q} == cnt_p1);
	assign sts.ins_last = (idx_q == pos_q);
	assign sts.rm_end   = (pos_q == cnt_q);
	assign sts.rm_last  = ({1'b0, idx_q} + (CNT_W+1)'(2) == {1'b0, cnt_q});
	assign sts.out_busy = out_valid_q & ~rsp_ready;

endmodule

@@ src/ple_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_ctrl
// Request sequencer: checks a request, walks the store for insert and remove
// shifts, and hands the finished result to the result register.
// ----------------------------------------------------------------------------
module ple_ctrl import ple_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  ple_sts_t sts,
	output ple_cmd_t cmd
);

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_CHECK   = 3'd1;
	localparam logic [2:0] S_RD_WAIT = 3'd2;
	localparam logic [2:0] S_INS     = 3'd3;
	localparam logic [2:0] S_INS_PUT = 3'd4;
	localparam logic [2:0] S_RM_DATA = 3'd5;
	localparam logic [2:0] S_RM      = 3'd6;
	localparam logic [2:0] S_DONE    = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign req_ready = (state_q == S_IDLE);

	// next state and commands
	always_comb begin
		state_d          = state_q;
		cmd              = '0;
		cmd.rd_sel       = RA_POS_M1;
		cmd.wr_sel       = WS_POS_VAL;
		cmd.idx_op       = IDX_HOLD;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				cmd.store_status = 1'b1;
				if (sts.err) begin
					state_d = S_DONE;
				end else begin
					case (sts.req_type)
						REQ_GET: begin
							cmd.rd_en = 1'b1;
							state_d   = S_RD_WAIT;
						end
						REQ_SET: begin
							cmd.wr_en = 1'b1;
							state_d   = S_DONE;
						end
						REQ_INSERT: begin
							if (sts.append) begin
								cmd.wr_en   = 1'b1;
								cmd.cnt_inc = 1'b1;
								state_d     = S_DONE;
							end else begin
								// first move: last entry up one slot
								cmd.rd_en  = 1'b1;
								cmd.rd_sel = RA_CNT_M1;
								cmd.idx_op = IDX_SET_CNT;
								state_d    = S_INS;
							end
						end
						REQ_REMOVE: begin
							cmd.rd_en  = 1'b1;
							cmd.idx_op = IDX_SET_POS1;
							state_d    = S_RM_DATA;
						end
						default: state_d = S_DONE;
					endcase
				end
			end
			S_RD_WAIT: begin
				cmd.data_cap = 1'b1;
				state_d      = S_DONE;
			end
			S_INS: begin
				// write the entry read last cycle one slot up
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = WS_IDX_RD;
				if (sts.ins_last) begin
					state_d = S_INS_PUT;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RA_IDX_M2;
					cmd.idx_op = IDX_DEC;
				end
			end
			S_INS_PUT: begin
				cmd.wr_en   = 1'b1;
				cmd.cnt_inc = 1'b1;
				state_d     = S_DONE;
			end
			S_RM_DATA: begin
				cmd.data_cap = 1'b1;
				if (sts.rm_end) begin
					cmd.cnt_dec = 1'b1;
					state_d     = S_DONE;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RA_IDX_P1;
					state_d    = S_RM;
				end
			end
			S_RM: begin
				// write the entry read last cycle one slot down
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = WS_IDX_RD;
				if (sts.rm_last) begin
					cmd.cnt_dec = 1'b1;
					state_d     = S_DONE;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RA_IDX_P2;
					cmd.idx_op = IDX_INC;
				end
			end
			S_DONE: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
